// File: hw/rtl/utf8_string_validator_core_macros.svh
// assertion macros shared by the utf8 validator rtl
// expects clk and rst_n in the scope of each use
`ifndef UTF8_STRING_VALIDATOR_CORE_MACROS_SVH
`define UTF8_STRING_VALIDATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define UTF8V_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`define UTF8V_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UTF8V_ASSERT(label, prop, msg)

`define UTF8V_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/utf8v_pkg.sv
// shared types, constants and helpers for the utf8 string validator
// no dependencies
package utf8v_pkg;

    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int MAX_BYTES_W         = 16;
    localparam int CP_W                = 21;
    localparam int BITS_W              = 6;

    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 16'd4096;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LOW     = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HIGH    = 21'h00dfff;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        byte_class_t         cls;
        logic [BITS_W-1:0]   bits;
        logic                last;
        logic                over_limit;
    } queue_entry_t;

    // least legal value for a sequence with the given continuation count
    function automatic logic [CP_W-1:0] least_value(input logic [1:0] seq_len);
        logic [CP_W-1:0] v;
        unique case (seq_len)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/utf8v_front.sv
// front end: takes bytes, classifies them and tracks the string length
// depends on utf8v_pkg
module utf8v_front
    import utf8v_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             byte_in,
    input  logic                   final_byte,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MAX_BYTES_W-1:0] max_bytes,
    input  logic                   queue_ready,
    output logic                   queue_push,
    output queue_entry_t           queue_entry
);

    localparam int CMP_W = (COUNT_BITS + 1 > MAX_BYTES_W) ? COUNT_BITS + 1 : MAX_BYTES_W;

    logic [MAX_BYTES_W-1:0] max_bytes_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [COUNT_BITS:0]    count_inc;
    logic                   accept;
    byte_class_t            cls;
    logic [BITS_W-1:0]      bits;

    assign in_ready   = queue_ready;
    assign cfg_ready  = 1'b1;
    assign accept     = in_valid && queue_ready;
    assign queue_push = accept;

    assign count_inc  = {1'b0, count_reg} + {{COUNT_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        if (final_byte)
        begin
            count_next = '0;
        end
        else if (count_inc[COUNT_BITS])
        begin
            count_next = '1;
        end
        else
        begin
            count_next = count_inc[COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        bits = '0;
        priority if (byte_in == 8'h00)
        begin
            cls = CLS_ZERO;
        end
        else if (!byte_in[7])
        begin
            cls = CLS_ASCII;
        end
        else if (byte_in[7:6] == 2'b10)
        begin
            cls  = CLS_CONT;
            bits = byte_in[5:0];
        end
        else if (byte_in[7:5] == 3'b110)
        begin
            cls  = CLS_LEAD2;
            bits = {1'b0, byte_in[4:0]};
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            cls  = CLS_LEAD3;
            bits = {2'b00, byte_in[3:0]};
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            cls  = CLS_LEAD4;
            bits = {3'b000, byte_in[2:0]};
        end
        else
        begin
            cls = CLS_BAD;
        end
    end

    always_comb
    begin
        queue_entry.cls        = cls;
        queue_entry.bits       = bits;
        queue_entry.last       = final_byte;
        queue_entry.over_limit = CMP_W'(count_inc) > CMP_W'(max_bytes_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_bytes_reg <= max_bytes;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

endmodule

// File: hw/rtl/utf8v_queue.sv
// short queue of classified bytes between front and back
// depends on utf8v_pkg
`include "utf8_string_validator_core_macros.svh"

module utf8v_queue
    import utf8v_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         push_ready,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         pop_valid,
    output queue_entry_t pop_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `UTF8V_ASSERT(a_count_in_range, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `UTF8V_ASSERT(a_no_underflow, !pop || count_reg != '0, "queue popped while empty")
    `UTF8V_ASSERT(a_no_overflow, !push || push_ready, "queue pushed while full")

endmodule

// File: hw/rtl/utf8v_back.sv
// back end: decodes sequences, holds the sticky failure and the verdict register
// depends on utf8v_pkg
`include "utf8_string_validator_core_macros.svh"

module utf8v_back
    import utf8v_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         entry_valid,
    input  queue_entry_t entry,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         is_valid
);

    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] cp_next;
    logic [1:0]      pend_reg;
    logic [1:0]      pend_next;
    logic [1:0]      seq_len_reg;
    logic [1:0]      seq_len_next;
    logic            failed_reg;
    logic            failed_next;
    logic            out_valid_reg;
    logic            is_valid_reg;
    logic            fail_in;
    logic            fail_str;
    logic            verdict;
    logic [CP_W-1:0] cp_shift;
    logic [1:0]      pend_dec;

    assign pop       = entry_valid && (!entry.last || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign is_valid  = is_valid_reg;

    assign cp_shift = {cp_reg[CP_W-BITS_W-1:0], entry.bits};
    assign pend_dec = pend_reg - 2'd1;
    assign fail_in  = failed_reg || entry.over_limit;

    always_comb
    begin
        cp_next      = cp_reg;
        pend_next    = pend_reg;
        seq_len_next = seq_len_reg;
        fail_str     = fail_in;
        if (!fail_in)
        begin
            priority if (entry.cls == CLS_ZERO)
            begin
                fail_str = 1'b1;
            end
            else if (pend_reg != 2'd0)
            begin
                if (entry.cls != CLS_CONT)
                begin
                    fail_str = 1'b1;
                end
                else
                begin
                    cp_next   = cp_shift;
                    pend_next = pend_dec;
                    if (pend_dec == 2'd0)
                    begin
                        if (cp_shift < least_value(seq_len_reg) || cp_shift > CP_MAX ||
                            (cp_shift >= SURR_LOW && cp_shift <= SURR_HIGH))
                        begin
                            fail_str = 1'b1;
                        end
                        cp_next      = '0;
                        seq_len_next = 2'd0;
                    end
                end
            end
            else
            begin
                unique case (entry.cls)
                    CLS_ASCII:
                    begin
                    end
                    CLS_LEAD2:
                    begin
                        cp_next      = CP_W'(entry.bits);
                        seq_len_next = 2'd1;
                        pend_next    = 2'd1;
                    end
                    CLS_LEAD3:
                    begin
                        cp_next      = CP_W'(entry.bits);
                        seq_len_next = 2'd2;
                        pend_next    = 2'd2;
                    end
                    CLS_LEAD4:
                    begin
                        cp_next      = CP_W'(entry.bits);
                        seq_len_next = 2'd3;
                        pend_next    = 2'd3;
                    end
                    default:
                    begin
                        fail_str = 1'b1;
                    end
                endcase
            end
        end
        failed_next = fail_str;
        // an open sequence at the last byte fails the string
        verdict     = !fail_str && pend_next == 2'd0;
        if (entry.last)
        begin
            cp_next      = '0;
            pend_next    = 2'd0;
            seq_len_next = 2'd0;
            failed_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg        <= '0;
            pend_reg      <= 2'd0;
            seq_len_reg   <= 2'd0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cp_reg      <= cp_next;
                pend_reg    <= pend_next;
                seq_len_reg <= seq_len_next;
                failed_reg  <= failed_next;
            end
            if (pop && entry.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && entry.last)
        begin
            is_valid_reg <= verdict;
        end
    end

    `UTF8V_ASSERT(a_pend_within_len, pend_reg <= seq_len_reg,
        "pending count above sequence length")
    `UTF8V_ASSERT(a_cp_clear_idle, pend_reg != 2'd0 || cp_reg == '0, "code point left over")
    `UTF8V_ASSERT_NEXT(a_clear_after_last, pop && entry.last,
        pend_reg == 2'd0 && seq_len_reg == 2'd0 && !failed_reg && out_valid_reg,
        "string state not cleared after last byte")

endmodule

// File: hw/rtl/utf8_string_validator_core.sv
// Streaming UTF-8 string checker. One byte is taken per cycle while the queue
// has room, with no gaps between strings; the front end classifies each byte
// and counts the length, a four-entry queue decouples it from the decoder, and
// the decoder retires one byte per cycle unless a final byte meets an untaken
// verdict. is_valid is registered as each final byte is retired, held in an
// output register so following bytes keep flowing while a verdict waits, until
// the next final byte reaches the decoder. max_bytes may be written only while
// the block is idle; cfg_ready is always high. No clearing pass.
//
// top level of the utf8 string validator
// depends on utf8v_pkg, utf8v_front, utf8v_queue and utf8v_back
module utf8_string_validator_core
    import utf8v_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             byte_in,
    input  logic                   final_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_valid,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MAX_BYTES_W-1:0] max_bytes
);

    logic         push;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop;
    logic         pop_valid;
    queue_entry_t pop_entry;

    utf8v_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .final_byte  (final_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .max_bytes   (max_bytes),
        .queue_ready (push_ready),
        .queue_push  (push),
        .queue_entry (push_entry)
    );

    utf8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    utf8v_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (pop_valid),
        .entry       (pop_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_valid    (is_valid)
    );

endmodule
